/* rtl/button_debounce_hold_edge_defines.svh */
// ----------------------------------------------------------------------------
// Button debouncer assertion macros
// Shared property shorthands for the debouncer RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_HOLD_EDGE_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_EDGE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define BDHE_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("debouncer check failed: same-cycle implication");

// Next-cycle implication, disabled while in reset
`define BDHE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("debouncer check failed: next-cycle implication");

`endif

/* rtl/bdhe_pkg.sv */
// ----------------------------------------------------------------------------
// Button debouncer package
// Widths, reset values, codes and record types shared by the debouncer RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package bdhe_pkg;

  localparam int TIME_W          = 32;
  localparam int CFG_W           = 16;
  localparam int LIM_W           = CFG_W + 1;
  localparam int PIN_W           = 3;
  localparam int IDX_W           = 8;
  localparam int OP_W            = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int NUM_BUTTONS_DEF = 3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd40;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_RISE   = 2'd1,
    OP_FALL   = 2'd2,
    OP_STATE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_HELD     = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_WINDOW   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD_HOLD,
    ST_UPD_DEB,
    ST_QRY_WIN,
    ST_QRY_NOW,
    ST_FINISH
  } state_e;

  // One button's stored record
  typedef struct packed {
    mode_e             mode;
    logic [TIME_W-1:0] deb_start;
    logic [TIME_W-1:0] hold_start;
    logic [TIME_W-1:0] rise;
    logic [TIME_W-1:0] fall;
  } btn_rec_t;

  // Per-field write enables plus new values for one button
  typedef struct packed {
    logic     we_mode;
    logic     we_deb;
    logic     we_hold;
    logic     we_rise;
    logic     we_fall;
    btn_rec_t val;
  } btn_wr_t;

endpackage

`default_nettype wire

/* rtl/bdhe_req_if.sv */
// ----------------------------------------------------------------------------
// Debouncer request channel
// Valid/ready channel carrying one update or query request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdhe_req_if;
  logic                           valid;
  logic                           ready;
  logic [bdhe_pkg::OP_W-1:0]      operation;
  logic [bdhe_pkg::TIME_W-1:0]    time_ms;
  logic [bdhe_pkg::PIN_W-1:0]     pin_levels;
  logic [bdhe_pkg::IDX_W-1:0]     button_index;

  modport source (output valid, operation, time_ms, pin_levels, button_index,
                  input ready);
  modport sink   (input valid, operation, time_ms, pin_levels, button_index,
                  output ready);
endinterface

`default_nettype wire

/* rtl/bdhe_rsp_if.sv */
// ----------------------------------------------------------------------------
// Debouncer response channel
// Valid/ready channel carrying one button status response.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdhe_rsp_if;
  logic valid;
  logic ready;
  logic is_released;
  logic is_pressed;
  logic is_held;
  logic edge_seen;

  modport source (output valid, is_released, is_pressed, is_held, edge_seen,
                  input ready);
  modport sink   (input valid, is_released, is_pressed, is_held, edge_seen,
                  output ready);
endinterface

`default_nettype wire

/* rtl/bdhe_elapsed.sv */
// ----------------------------------------------------------------------------
// Elapsed-time compare unit
// Wrapping subtract of two millisecond stamps, compared at-least with a limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bdhe_elapsed (
  input  logic [bdhe_pkg::TIME_W-1:0] now_i,
  input  logic [bdhe_pkg::TIME_W-1:0] start_i,
  input  logic [bdhe_pkg::LIM_W-1:0]  limit_i,
  output logic                        elapsed_o
);
  import bdhe_pkg::*;

  logic [TIME_W-1:0] diff;

  // Subtract modulo 2^32, then compare against the zero-extended limit
  assign diff      = now_i - start_i;
  assign elapsed_o = (diff >= TIME_W'(limit_i));

endmodule

`default_nettype wire

/* rtl/bdhe_regfile.sv */
// ----------------------------------------------------------------------------
// Button record file
// Per-button mode and time stamps, one read and one write address.
// ----------------------------------------------------------------------------
`default_nettype none

module bdhe_regfile #(
  parameter int NUM_BUTTONS = bdhe_pkg::NUM_BUTTONS_DEF,
  parameter int BW          = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BW-1:0]      wr_addr_i,
  input  bdhe_pkg::btn_wr_t  wr_i,
  input  logic [BW-1:0]      rd_addr_i,
  output bdhe_pkg::btn_rec_t rd_o
);
  import bdhe_pkg::*;

  btn_rec_t rec_q [NUM_BUTTONS];

  // Read the addressed record
  assign rd_o = rec_q[rd_addr_i];

  // Write selected fields, clear every record at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        rec_q[b].mode       <= MODE_RELEASED;
        rec_q[b].deb_start  <= '0;
        rec_q[b].hold_start <= '0;
        rec_q[b].rise       <= '0;
        rec_q[b].fall       <= '0;
      end
    end else begin
      if (wr_i.we_mode) rec_q[wr_addr_i].mode       <= wr_i.val.mode;
      if (wr_i.we_deb)  rec_q[wr_addr_i].deb_start  <= wr_i.val.deb_start;
      if (wr_i.we_hold) rec_q[wr_addr_i].hold_start <= wr_i.val.hold_start;
      if (wr_i.we_rise) rec_q[wr_addr_i].rise       <= wr_i.val.rise;
      if (wr_i.we_fall) rec_q[wr_addr_i].fall       <= wr_i.val.fall;
    end
  end

endmodule

`default_nettype wire

/* rtl/button_debounce_hold_edge.sv */
// ----------------------------------------------------------------------------
// Button debouncer with long press and edge stamps
// Debounces active-low buttons under a sequencer around one compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries a request: operation, time_ms, pin_levels, button_index.
//   An update steps every button; edge and state queries read one button.
//   rsp_o returns one response per request: is_released, is_pressed,
//   is_held and edge_seen, held in an output register until taken.
//   cfg_we_i/cfg_index_i/cfg_data_i write debounce, hold and window times;
//   write them only while no request is in flight.
// Steps per request (sequencer states in order):
//   update: a hold step and a debounce step per button, two compares per
//   button on the single subtract-and-compare unit, then finish; rising or
//   falling edge query: window, now, finish; state query or out-of-range
//   index: finish. The response is valid in the cycle after the finish step.
// Reset: all buttons released, all stamps zero, times back to 50/1000/40 ms.
// Stall: a held response lets the next request in; that request waits in
//   its final step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_hold_edge_defines.svh"

module button_debounce_hold_edge #(
  parameter int NUM_BUTTONS = bdhe_pkg::NUM_BUTTONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bdhe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bdhe_pkg::CFG_W-1:0]     cfg_data_i,
  bdhe_req_if.sink                       req_i,
  bdhe_rsp_if.source                     rsp_o
);
  import bdhe_pkg::*;

  localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] deb_ms_q, hold_ms_q, win_ms_q;

  op_e               op_q;
  logic [TIME_W-1:0] now_q;
  logic [PIN_W-1:0]  pins_q;
  logic [BW-1:0]     idx_q;
  logic              idx_ok_q;
  logic [BW-1:0]     btn_q;
  logic              hold_hit_q;
  logic              win_q;
  logic              edge_q;

  logic rsp_valid_q;
  logic rel_q, press_q, held_q, seen_q;

  logic              req_acc;
  op_e               req_op;
  logic              req_idx_ok;
  logic              out_free;
  logic              last_btn;
  logic              pin_high;
  logic              rest_mode;
  logic              restart;
  logic [BW-1:0]     rf_addr;
  btn_rec_t          rd;
  btn_wr_t           wr;
  logic [TIME_W-1:0] cmp_start;
  logic [LIM_W-1:0]  cmp_limit;
  logic              cmp_el;

  assign req_op     = op_e'(req_i.operation);
  assign req_idx_ok = (req_i.button_index < IDX_W'(NUM_BUTTONS));
  assign req_acc    = req_i.valid && req_i.ready;
  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign last_btn   = (btn_q == BW'(NUM_BUTTONS - 1));

  // Level of the button being stepped; buttons past the pin field read low
  always_comb begin
    pin_high = 1'b0;
    for (int k = 0; k < PIN_W; k++) begin
      if (32'(btn_q) == k) pin_high = pins_q[k];
    end
  end

  assign rest_mode = (rd.mode != MODE_PRESSED) && (rd.mode != MODE_HELD);
  assign restart   = rest_mode ? pin_high : !pin_high;

  // Record file address: stepped button during updates, queried one otherwise
  assign rf_addr = ((state_q == ST_UPD_HOLD) || (state_q == ST_UPD_DEB)) ? btn_q : idx_q;

  bdhe_regfile #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .BW          (BW)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_addr_i (rf_addr),
    .wr_i      (wr),
    .rd_addr_i (rf_addr),
    .rd_o      (rd)
  );

  bdhe_elapsed u_elapsed (
    .now_i     (now_q),
    .start_i   (cmp_start),
    .limit_i   (cmp_limit),
    .elapsed_o (cmp_el)
  );

  // Sequence the steps of one request
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (req_op == OP_UPDATE) begin
            state_d = ST_UPD_HOLD;
          end else if (!req_idx_ok || (req_op == OP_STATE)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_QRY_WIN;
          end
        end
      end
      ST_UPD_HOLD: state_d = ST_UPD_DEB;
      ST_UPD_DEB:  state_d = last_btn ? ST_FINISH : ST_UPD_HOLD;
      ST_QRY_WIN:  state_d = ST_QRY_NOW;
      ST_QRY_NOW:  state_d = ST_FINISH;
      ST_FINISH:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Drive the compare unit, the record writes and the request ready
  always_comb begin
    cmp_start = '0;
    cmp_limit = '0;
    wr        = '0;
    wr.val.mode = MODE_RELEASED;
    req_i.ready = (state_q == ST_IDLE);
    unique case (state_q)
      ST_UPD_HOLD: begin
        cmp_start = rd.hold_start;
        cmp_limit = {1'b0, hold_ms_q};
      end
      ST_UPD_DEB: begin
        cmp_start        = restart ? now_q : rd.deb_start;
        cmp_limit        = {1'b0, deb_ms_q};
        wr.we_deb        = restart;
        wr.val.deb_start = now_q;
        wr.val.rise      = now_q;
        wr.val.hold_start = now_q;
        wr.val.fall      = now_q;
        if (rest_mode) begin
          if (cmp_el) begin
            wr.we_mode  = 1'b1;
            wr.we_rise  = 1'b1;
            wr.we_hold  = 1'b1;
            wr.val.mode = MODE_PRESSED;
          end
        end else if (cmp_el) begin
          wr.we_mode  = 1'b1;
          wr.we_fall  = 1'b1;
          wr.val.mode = MODE_RELEASED;
        end else if (hold_hit_q) begin
          wr.we_mode  = 1'b1;
          wr.val.mode = MODE_HELD;
        end
      end
      ST_QRY_WIN: begin
        cmp_start = (op_q == OP_RISE) ? rd.rise : rd.fall;
        cmp_limit = {1'b0, win_ms_q};
      end
      ST_QRY_NOW: begin
        // now > window is the same as now - 0 >= window + 1
        cmp_start  = '0;
        cmp_limit  = {1'b0, win_ms_q} + LIM_W'(1);
        wr.we_rise = (op_q == OP_RISE);
        wr.we_fall = (op_q == OP_FALL);
        wr.val.rise = '0;
        wr.val.fall = '0;
      end
      default: begin
      end
    endcase
  end

  // Hold state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      deb_ms_q    <= DEBOUNCE_RST;
      hold_ms_q   <= HOLD_RST;
      win_ms_q    <= WINDOW_RST;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_FINISH) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_DEBOUNCE: deb_ms_q  <= cfg_data_i;
          CFG_HOLD:     hold_ms_q <= cfg_data_i;
          CFG_WINDOW:   win_ms_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Capture the request and advance the working registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q     <= req_op;
      now_q    <= req_i.time_ms;
      pins_q   <= req_i.pin_levels;
      idx_q    <= req_i.button_index[BW-1:0];
      idx_ok_q <= req_idx_ok;
      btn_q    <= '0;
    end
    if (state_q == ST_UPD_HOLD) begin
      hold_hit_q <= (rd.mode == MODE_PRESSED) && !pin_high && cmp_el;
    end
    if (state_q == ST_UPD_DEB) begin
      btn_q <= btn_q + BW'(1);
    end
    if (state_q == ST_QRY_WIN) begin
      win_q <= cmp_el;
    end
    if (state_q == ST_QRY_NOW) begin
      edge_q <= !win_q && cmp_el;
    end
    if ((state_q == ST_FINISH) && out_free) begin
      if ((op_q == OP_UPDATE) || !idx_ok_q) begin
        rel_q   <= 1'b0;
        press_q <= 1'b0;
        held_q  <= 1'b0;
        seen_q  <= 1'b0;
      end else begin
        rel_q   <= (rd.mode != MODE_PRESSED) && (rd.mode != MODE_HELD);
        press_q <= (rd.mode == MODE_PRESSED) || (rd.mode == MODE_HELD);
        held_q  <= (rd.mode == MODE_HELD);
        seen_q  <= ((op_q == OP_RISE) || (op_q == OP_FALL)) && edge_q;
      end
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.is_released = rel_q;
  assign rsp_o.is_pressed  = press_q;
  assign rsp_o.is_held     = held_q;
  assign rsp_o.edge_seen   = seen_q;

  // An update request starts at the first button
  `BDHE_ASSERT_NEXT(a_upd_start, clk_i, rst_ni, req_acc && (req_op == OP_UPDATE), (state_q == ST_UPD_HOLD) && (btn_q == '0))

  // Only in-range queries reach the stamp-clearing step
  `BDHE_ASSERT_IMPLY(a_qry_in_range, clk_i, rst_ni, state_q == ST_QRY_NOW, idx_ok_q)

  // Records change only in the debounce step or the stamp-clearing step
  `BDHE_ASSERT_IMPLY(a_wr_window, clk_i, rst_ni, wr.we_mode || wr.we_deb || wr.we_hold || wr.we_rise || wr.we_fall, (state_q == ST_UPD_DEB) || (state_q == ST_QRY_NOW))

  // A finished request shows up on the output and frees the sequencer
  `BDHE_ASSERT_NEXT(a_finish_out, clk_i, rst_ni, (state_q == ST_FINISH) && out_free, rsp_valid_q && (state_q == ST_IDLE))

endmodule

`default_nettype wire

/* bench/tb_button_debounce_hold_edge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debouncer testbench
// Sends updates and edge/state queries over the request channel and checks
// every response against an in-bench model of the three debounced buttons.
// A short table of directed requests comes first. Random phases follow, each
// under its own debounce/hold/window times, with time wrap and pin bounce.
// ----------------------------------------------------------------------------

module tb_button_debounce_hold_edge;
  import bdhe_pkg::*;

  localparam int NUM_BTN     = NUM_BUTTONS_DEF;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 115;
  localparam int DIR_N       = 24;
  localparam int CYCLE_LIMIT = 400000;

  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic released;
    logic pressed;
    logic held;
    logic edge_seen;
  } status_t;

  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] t_ms;
    logic [PIN_W-1:0]  pins;
    logic [IDX_W-1:0]  idx;
    bit                typed;
    status_t           want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bdhe_req_if req_if ();
  bdhe_rsp_if rsp_if ();

  button_debounce_hold_edge dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Button model: configuration and per-button records
  logic [CFG_W-1:0]  deb_ms;
  logic [CFG_W-1:0]  hold_ms;
  logic [CFG_W-1:0]  win_ms;
  mode_e             btn_mode   [NUM_BTN];
  logic [TIME_W-1:0] deb_start  [NUM_BTN];
  logic [TIME_W-1:0] hold_start [NUM_BTN];
  logic [TIME_W-1:0] rise_stamp [NUM_BTN];
  logic [TIME_W-1:0] fall_stamp [NUM_BTN];

  status_t status_q [$];
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;
  bit      steady_flow = 1'b0;

  // Directed requests under the reset times 50/1000/40 ms
  dir_row_t dir_rows [DIR_N] = '{
    // after reset: released, nothing stamped, time not past the window
    '{OP_STATE,  32'd0,          3'b111, 8'd0,   1'b1, 4'b1000},
    '{OP_RISE,   32'd0,          3'b111, 8'd0,   1'b1, 4'b1000},
    '{OP_FALL,   32'd0,          3'b111, 8'd2,   1'b1, 4'b1000},
    // index out of range: all zeros
    '{OP_STATE,  32'd5,          3'b111, 8'd3,   1'b1, 4'b0000},
    '{OP_RISE,   32'd5,          3'b111, 8'd255, 1'b1, 4'b0000},
    '{OP_FALL,   32'd5,          3'b111, 8'd128, 1'b1, 4'b0000},
    // press buttons 0 and 2, read the rising edge twice
    '{OP_UPDATE, 32'd0,          3'b111, 8'd0,   1'b1, 4'b0000},
    '{OP_UPDATE, 32'd20,         3'b000, 8'd0,   1'b1, 4'b0000},
    '{OP_UPDATE, 32'd60,         3'b010, 8'd0,   1'b1, 4'b0000},
    '{OP_RISE,   32'd70,         3'b111, 8'd0,   1'b0, 4'b0000},
    '{OP_RISE,   32'd75,         3'b111, 8'd0,   1'b0, 4'b0000},
    // long press turns held, then release and press button 1
    '{OP_UPDATE, 32'd1070,       3'b010, 8'd0,   1'b1, 4'b0000},
    '{OP_STATE,  32'd1070,       3'b111, 8'd0,   1'b0, 4'b0000},
    '{OP_UPDATE, 32'd1080,       3'b101, 8'd0,   1'b1, 4'b0000},
    '{OP_UPDATE, 32'd1130,       3'b101, 8'd0,   1'b1, 4'b0000},
    '{OP_FALL,   32'd1140,       3'b111, 8'd0,   1'b0, 4'b0000},
    '{OP_RISE,   32'd1140,       3'b111, 8'd1,   1'b0, 4'b0000},
    '{OP_STATE,  32'd1140,       3'b111, 8'd2,   1'b0, 4'b0000},
    // time wraps through zero
    '{OP_UPDATE, 32'hFFFF_FFF0,  3'b110, 8'd0,   1'b1, 4'b0000},
    '{OP_UPDATE, 32'hFFFF_FFFF,  3'b001, 8'd0,   1'b1, 4'b0000},
    '{OP_UPDATE, 32'h0000_0010,  3'b100, 8'd0,   1'b1, 4'b0000},
    '{OP_RISE,   32'h0000_0010,  3'b111, 8'd0,   1'b0, 4'b0000},
    '{OP_FALL,   32'hFFFF_FFFF,  3'b111, 8'd1,   1'b0, 4'b0000},
    '{OP_STATE,  32'hFFFF_FFFF,  3'b111, 8'd2,   1'b0, 4'b0000}
  };

  function automatic bit ms_elapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] start,
                                    logic [CFG_W-1:0] lim);
    logic [TIME_W-1:0] diff;
    diff = now - start;
    return diff >= {16'd0, lim};
  endfunction

  // Advance one button's released/pressed/held machine
  function automatic void step_button(int b, logic [TIME_W-1:0] now, logic pin_high);
    case (btn_mode[b])
      MODE_PRESSED: begin
        if (!pin_high) begin
          deb_start[b] = now;
          if (ms_elapsed(now, hold_start[b], hold_ms)) btn_mode[b] = MODE_HELD;
        end
        if (ms_elapsed(now, deb_start[b], deb_ms)) begin
          fall_stamp[b] = now;
          btn_mode[b]   = MODE_RELEASED;
        end
      end
      MODE_HELD: begin
        if (!pin_high) deb_start[b] = now;
        if (ms_elapsed(now, deb_start[b], deb_ms)) begin
          fall_stamp[b] = now;
          btn_mode[b]   = MODE_RELEASED;
        end
      end
      default: begin
        if (pin_high) deb_start[b] = now;
        if (ms_elapsed(now, deb_start[b], deb_ms)) begin
          rise_stamp[b] = now;
          hold_start[b] = now;
          btn_mode[b]   = MODE_PRESSED;
        end
      end
    endcase
  endfunction

  // Apply one request to the model and return the status it answers with
  function automatic status_t predict_status(op_e op, logic [TIME_W-1:0] now,
                                             logic [PIN_W-1:0] pins, logic [IDX_W-1:0] idx);
    status_t res;
    int      b;
    res = '0;
    if (op == OP_UPDATE) begin
      for (b = 0; b < NUM_BTN; b++) step_button(b, now, pins[b]);
      return res;
    end
    if (idx >= NUM_BTN) return res;
    b = int'(idx);
    if (op == OP_RISE) begin
      res.edge_seen = !ms_elapsed(now, rise_stamp[b], win_ms) && (now > win_ms);
      rise_stamp[b] = '0;
    end else if (op == OP_FALL) begin
      res.edge_seen = !ms_elapsed(now, fall_stamp[b], win_ms) && (now > win_ms);
      fall_stamp[b] = '0;
    end
    res.pressed  = (btn_mode[b] == MODE_PRESSED) || (btn_mode[b] == MODE_HELD);
    res.released = !res.pressed;
    res.held     = (btn_mode[b] == MODE_HELD);
    return res;
  endfunction

  // Hold off, present one request, wait for it to be taken, then predict
  task automatic send_request(op_e op, logic [TIME_W-1:0] t_ms, logic [PIN_W-1:0] pins,
                              logic [IDX_W-1:0] idx, bit typed, status_t want);
    int      gap;
    status_t model_res;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.time_ms      <= t_ms;
    req_if.pin_levels   <= pins;
    req_if.button_index <= idx;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    model_res = predict_status(op, t_ms, pins, idx);
    status_q.push_back(typed ? want : model_res);
  endtask

  // Drop valid and wait until every response is back
  task automatic drain_requests();
    req_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CFG_DEBOUNCE: deb_ms  = val;
      CFG_HOLD:     hold_ms = val;
      CFG_WINDOW:   win_ms  = val;
      default: ;
    endcase
  endtask

  task automatic note_mismatch(string what, status_t want, status_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s: expected rel=%b prs=%b held=%b edge=%b, got rel=%b prs=%b held=%b edge=%b",
               $time, what, want.released, want.pressed, want.held, want.edge_seen,
               got.released, got.pressed, got.held, got.edge_seen);
  endtask

  // Drive the main stimulus: reset, directed table, random phases
  initial begin : stimulus
    int                ph;
    int                n;
    int                k;
    int                roll;
    op_e               op;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] t_ms;
    logic [PIN_W-1:0]  level_hold;
    logic [PIN_W-1:0]  pins;
    logic [IDX_W-1:0]  idx;
    logic [CFG_W-1:0]  ph_deb  [PHASES];
    logic [CFG_W-1:0]  ph_hold [PHASES];
    logic [CFG_W-1:0]  ph_win  [PHASES];

    ph_deb  = '{16'd1, 16'd5,  16'hFFFF, 16'd0, 16'd3,  16'd8};
    ph_hold = '{16'd1, 16'd20, 16'hFFFF, 16'd0, 16'd15, 16'd40};
    ph_win  = '{16'd1, 16'd8,  16'hFFFF, 16'd0, 16'd6,  16'd10};

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_index_i         <= CFG_DEBOUNCE;
    cfg_data_i          <= '0;
    req_if.valid        <= 1'b0;
    req_if.operation    <= OP_UPDATE;
    req_if.time_ms      <= '0;
    req_if.pin_levels   <= '0;
    req_if.button_index <= '0;

    deb_ms  = DEBOUNCE_RST;
    hold_ms = HOLD_RST;
    win_ms  = WINDOW_RST;
    for (k = 0; k < NUM_BTN; k++) begin
      btn_mode[k]   = MODE_RELEASED;
      deb_start[k]  = '0;
      hold_start[k] = '0;
      rise_stamp[k] = '0;
      fall_stamp[k] = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DIR_N; k++)
      send_request(dir_rows[k].op, dir_rows[k].t_ms, dir_rows[k].pins, dir_rows[k].idx,
                   dir_rows[k].typed, dir_rows[k].want);

    for (ph = 0; ph < PHASES; ph++) begin
      drain_requests();
      if (ph == PHASES - 1) begin
        ph_deb[ph]  = CFG_W'($urandom_range(1, 12));
        ph_hold[ph] = CFG_W'($urandom_range(1, 60));
        ph_win[ph]  = CFG_W'($urandom_range(1, 20));
      end
      write_cfg(CFG_DEBOUNCE, ph_deb[ph]);
      write_cfg(CFG_HOLD, ph_hold[ph]);
      write_cfg(CFG_WINDOW, ph_win[ph]);
      write_cfg(CFG_SPARE, CFG_W'($urandom));
      cfg_we_i <= 1'b0;

      // odd phases start just short of the time wrap
      if (ph % 2 == 1) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * deb_ms + 100);
      else             now_ms = $urandom;
      level_hold = PIN_W'($urandom);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          // noise: anything the fields allow
          op   = op_e'($urandom_range(0, 3));
          t_ms = $urandom;
          pins = PIN_W'($urandom);
          idx  = IDX_W'($urandom_range(0, 255));
        end else if (roll < 68) begin
          // update: time moves on, levels mostly steady with some bounce
          op     = OP_UPDATE;
          now_ms = now_ms + $urandom_range(0, (deb_ms >> 2) + 2);
          for (k = 0; k < NUM_BTN; k++)
            if ($urandom_range(0, 5) == 0) level_hold[k] = ~level_hold[k];
          pins = level_hold;
          if ($urandom_range(0, 99) < 15) pins = pins ^ PIN_W'($urandom);
          t_ms = now_ms;
          idx  = IDX_W'($urandom_range(0, 255));
        end else begin
          op   = op_e'($urandom_range(1, 3));
          t_ms = now_ms;
          if ($urandom_range(0, 3) == 0) t_ms = now_ms + $urandom_range(0, win_ms + 2);
          pins = PIN_W'($urandom);
          idx  = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(3, 255))
                                              : IDX_W'($urandom_range(0, 2));
        end
        send_request(op, t_ms, pins, idx, 1'b0, '0);
        if ($urandom_range(0, 49) == 0) drain_requests();
      end
    end

    drain_requests();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && status_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Take responses after a random stall per response
  initial begin : response_sink
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // Compare each taken response with the oldest pending status
  always @(posedge clk_i) begin : check_status
    status_t got;
    status_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.is_released, rsp_if.is_pressed, rsp_if.is_held, rsp_if.edge_seen};
      if (status_q.size() == 0) begin
        note_mismatch("response with no request pending", '0, got);
      end else begin
        want = status_q.pop_front();
        if (got.released !== want.released || got.pressed !== want.pressed ||
            got.held !== want.held || got.edge_seen !== want.edge_seen)
          note_mismatch("status mismatch", want, got);
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
